// ----- sv/rmh_pkg.sv -----
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared state type for the running median tracker.
// ----------------------------------------------------------------------------
package rmh_pkg;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_PUSH_RD  = 11'b00000000010,
    S_PUSH_CMP = 11'b00000000100,
    S_POP_TOP  = 11'b00000001000,
    S_POP_LAST = 11'b00000010000,
    S_POP_HOLD = 11'b00000100000,
    S_DN_L     = 11'b00001000000,
    S_DN_R     = 11'b00010000000,
    S_DN_CMP   = 11'b00100000000,
    S_TOP      = 11'b01000000000,
    S_TOP_RD   = 11'b10000000000
  } state_t;

endpackage

// ----- sv/running_median_two_heaps_top.sv -----
// ----------------------------------------------------------------------------
// running_median_two_heaps_top
// Running median tracker over a max-heap and a min-heap in RAM.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with sample and restart. Output channel:
// out_valid/out_stall with median and dropped, one transaction per input.
// Each heap sits in its own RAM with a registered read, so a sift step is a
// read then a compare and write: on a push the parent read, then compare and
// write; on a pop the left child, the right child, then compare and write.
// An input costs a push, a rebalance pop and a second push when the heaps are
// out of balance, and a read back of the new lower top. A dropped sample gives
// its result through the done and output registers. One item is in work at
// a time: in_stall is high while the engine runs and while a result waits,
// so the next input is taken once the result has been taken.
// Reset empties both heaps (counts to zero); heap RAM contents are left as is.
// A stalled result holds in the output register until taken.
// ----------------------------------------------------------------------------
module running_median_two_heaps_top
  import rmh_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] sample,
  input  logic                   restart,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] median,
  output logic                   dropped
);

  logic busy, done, drop;
  logic [VALUE_WIDTH-1:0] top;
  logic start;

  assign in_stall = busy || out_valid;
  assign start = in_valid && !in_stall;

  rmh_heap_engine #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_eng (
    .clk(clk), .rst(rst), .start(start), .value(sample), .clear(restart),
    .busy(busy), .done(done), .top(top), .full_drop(drop));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (done) begin
        out_valid <= 1'b1;
        median <= top;
        dropped <= drop;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/rmh_ram.sv -----
// ----------------------------------------------------------------------------
// rmh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rmh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/rmh_heap_engine.sv -----
// ----------------------------------------------------------------------------
// rmh_heap_engine
// Sequencer for insert, rebalance pop and push on two heaps held in RAM.
// ----------------------------------------------------------------------------
module rmh_heap_engine
  import rmh_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   clear,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] top,
  output logic                   full_drop
);

  localparam int HD = CAPACITY / 2 + 2;
  localparam int AW = $clog2(HD);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (AW + 2 > CW) ? AW + 2 : CW;

  state_t state;
  logic [CW-1:0] lcnt, ucnt;
  logic [AW-1:0] idx;
  logic signed [VALUE_WIDTH-1:0] cur, lval, ltop, moved;
  logic side;        // 1: lower (max) heap
  logic rebal;       // rebalance pending after current push

  logic we, we_l, we_u;
  logic [AW-1:0] addr;
  logic [VALUE_WIDTH-1:0] wdata, rd_l, rd_u;
  logic signed [VALUE_WIDTH-1:0] rd;
  logic [CW-1:0] n;
  logic [XW-1:0] n_x, lft_x, rgt_x;
  logic [AW-1:0] parent_w;
  logic [CW-1:0] l0, u0;
  logic full_in, go_lower;
  state_t ap_state;
  logic ap_side;
  logic dn_left, dn_right, dn_move;
  logic signed [VALUE_WIDTH-1:0] dn_val;
  logic [AW-1:0] dn_idx;

  rmh_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(HD)) u_low (
    .clk(clk), .we(we_l), .addr(addr), .wdata(wdata), .rdata(rd_l));
  rmh_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(HD)) u_up (
    .clk(clk), .we(we_u), .addr(addr), .wdata(wdata), .rdata(rd_u));

  assign rd = side ? $signed(rd_l) : $signed(rd_u);
  assign n  = side ? lcnt : ucnt;
  assign busy = (state != S_IDLE) || done;
  assign top = ltop;

  function automatic logic above(logic signed [VALUE_WIDTH-1:0] a,
                                 logic signed [VALUE_WIDTH-1:0] b, logic mx);
    above = mx ? (a > b) : (a < b);
  endfunction

  assign n_x      = XW'(n);
  assign lft_x    = XW'({idx, 1'b1});
  assign rgt_x    = lft_x + XW'(1);
  assign parent_w = (idx - AW'(1)) >> 1;

  assign l0       = clear ? '0 : lcnt;
  assign u0       = clear ? '0 : ucnt;
  assign full_in  = ({1'b0, l0} + {1'b0, u0}) >= (CW+1)'(CAPACITY);
  assign go_lower = (l0 == '0) || ($signed(value) <= ltop);

  // sift-down: hole at idx, cur is the value being placed
  assign dn_left  = above(lval, cur, side);
  assign dn_right = (rgt_x < n_x) && above(rd, dn_left ? lval : cur, side);
  assign dn_move  = dn_left || dn_right;
  assign dn_val   = dn_right ? rd : lval;
  assign dn_idx   = dn_right ? rgt_x[AW-1:0] : lft_x[AW-1:0];

  // where to go once a push has placed its value
  always_comb begin
    ap_state = S_TOP;
    ap_side  = 1'b1;
    if (rebal) begin
      if (lcnt > ucnt + CW'(1)) begin
        ap_state = S_POP_TOP;
      end else if (ucnt > lcnt) begin
        ap_state = S_POP_TOP;
        ap_side  = 1'b0;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    addr  = idx;
    wdata = cur;
    unique case (state)
      S_PUSH_RD: begin
        if (idx == '0) we = 1'b1;
        else addr = parent_w;
      end
      S_PUSH_CMP: begin
        we = 1'b1;
        if (above(cur, rd, side)) wdata = rd;
      end
      S_POP_TOP: addr = '0;
      S_POP_LAST: addr = n[AW-1:0];
      S_DN_L: begin
        if (lft_x < n_x) addr = lft_x[AW-1:0];
        else we = 1'b1;
      end
      S_DN_R: addr = rgt_x[AW-1:0];
      S_DN_CMP: begin
        we = 1'b1;
        if (dn_move) wdata = dn_val;
      end
      S_TOP: addr = '0;
      default: ;
    endcase
  end

  assign we_l = we && side;
  assign we_u = we && !side;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lcnt <= '0;
      ucnt <= '0;
      done <= 1'b0;
      full_drop <= 1'b0;
      ltop <= '0;
      side <= 1'b0;
      rebal <= 1'b0;
      idx <= '0;
      cur <= '0;
      lval <= '0;
      moved <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (full_in) begin
              lcnt <= l0;
              ucnt <= u0;
              full_drop <= 1'b1;
              done <= 1'b1;
            end else begin
              full_drop <= 1'b0;
              cur <= $signed(value);
              side <= go_lower;
              rebal <= 1'b1;
              if (go_lower) begin
                idx <= l0[AW-1:0];
                lcnt <= l0 + CW'(1);
                ucnt <= u0;
              end else begin
                idx <= u0[AW-1:0];
                ucnt <= u0 + CW'(1);
                lcnt <= l0;
              end
              state <= S_PUSH_RD;
            end
          end
        end
        S_PUSH_RD: begin
          if (idx == '0) begin
            state <= ap_state;
            side <= ap_side;
            rebal <= 1'b0;
          end else begin
            state <= S_PUSH_CMP;
          end
        end
        S_PUSH_CMP: begin
          if (above(cur, rd, side)) begin
            idx <= parent_w;
            state <= S_PUSH_RD;
          end else begin
            state <= ap_state;
            side <= ap_side;
            rebal <= 1'b0;
          end
        end
        S_POP_TOP: begin
          if (side) lcnt <= lcnt - CW'(1);
          else ucnt <= ucnt - CW'(1);
          state <= S_POP_LAST;
        end
        S_POP_LAST: begin
          moved <= rd;
          state <= S_POP_HOLD;
        end
        S_POP_HOLD: begin
          cur <= rd;
          idx <= '0;
          state <= S_DN_L;
        end
        S_DN_L: begin
          if (lft_x < n_x) begin
            state <= S_DN_R;
          end else begin
            side <= !side;
            cur <= moved;
            if (side) begin
              idx <= ucnt[AW-1:0];
              ucnt <= ucnt + CW'(1);
            end else begin
              idx <= lcnt[AW-1:0];
              lcnt <= lcnt + CW'(1);
            end
            state <= S_PUSH_RD;
          end
        end
        S_DN_R: begin
          lval <= rd;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_move) begin
            idx <= dn_idx;
            state <= S_DN_L;
          end else begin
            side <= !side;
            cur <= moved;
            if (side) begin
              idx <= ucnt[AW-1:0];
              ucnt <= ucnt + CW'(1);
            end else begin
              idx <= lcnt[AW-1:0];
              lcnt <= lcnt + CW'(1);
            end
            state <= S_PUSH_RD;
          end
        end
        S_TOP: state <= S_TOP_RD;
        S_TOP_RD: begin
          ltop <= rd;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sv/running_median_two_heaps_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_top_test
// Drives signed samples, with restarts, into the running median tracker. It
// predicts each median and drop flag with its own pair of heaps and checks
// every output transaction in order. A short directed table comes first, then
// a random sequence that fills the store and runs past full, under random
// input gaps and output stalls, then short random sequences.
// ----------------------------------------------------------------------------
module running_median_two_heaps_top_test;

  localparam int CAP = 1024;
  localparam int VW = 16;
  localparam int HALF = CAP / 2 + 2;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [VW-1:0] median;
    logic          dropped;
  } median_result_t;

  typedef struct {
    logic [VW-1:0] sample;
    logic          restart;
    logic          known;
    logic [VW-1:0] median;
    logic          dropped;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [VW-1:0] sample = '0;
  logic          restart = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [VW-1:0] median;
  logic          dropped;

  always #1 clk = ~clk;

  running_median_two_heaps_top #(.CAPACITY(CAP), .VALUE_WIDTH(VW)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .restart(restart), .out_valid(out_valid),
    .out_stall(out_stall), .median(median), .dropped(dropped)
  );

  // predictor state
  logic signed [VW-1:0] lo_heap [HALF];
  logic signed [VW-1:0] hi_heap [HALF];
  int lo_n, hi_n;
  median_result_t medians_due[$];
  int errors;
  longint cycles;

  task automatic report(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic bit outranks(input logic signed [VW-1:0] a,
                                  input logic signed [VW-1:0] b, input bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  function automatic void heap_insert(input bit is_max, input logic signed [VW-1:0] v);
    int i, p;
    logic signed [VW-1:0] t;
    i = is_max ? lo_n : hi_n;
    if (is_max) begin lo_heap[i] = v; lo_n++; end
    else begin hi_heap[i] = v; hi_n++; end
    while (i > 0) begin
      p = (i - 1) / 2;
      if (is_max) begin
        if (!outranks(lo_heap[i], lo_heap[p], 1)) break;
        t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
      end else begin
        if (!outranks(hi_heap[i], hi_heap[p], 0)) break;
        t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
      end
      i = p;
    end
  endfunction

  function automatic void heap_extract(input bit is_max,
                                       output logic signed [VW-1:0] top);
    int n, i, l, r, best;
    logic signed [VW-1:0] h [HALF];
    logic signed [VW-1:0] t;
    if (is_max) begin
      h = lo_heap;
      n = lo_n - 1;
    end else begin
      h = hi_heap;
      n = hi_n - 1;
    end
    top = h[0];
    h[0] = h[n];
    i = 0;
    forever begin
      l = 2 * i + 1; r = l + 1; best = i;
      if (l < n && outranks(h[l], h[best], is_max)) best = l;
      if (r < n && outranks(h[r], h[best], is_max)) best = r;
      if (best == i) break;
      t = h[i]; h[i] = h[best]; h[best] = t;
      i = best;
    end
    if (is_max) begin lo_heap = h; lo_n = n; end
    else begin hi_heap = h; hi_n = n; end
  endfunction

  function automatic median_result_t track_median(input logic [VW-1:0] s,
                                                  input logic rs);
    median_result_t r;
    logic signed [VW-1:0] m;
    r.dropped = 1'b0;
    if (rs) begin lo_n = 0; hi_n = 0; end
    if (lo_n + hi_n >= CAP) r.dropped = 1'b1;
    else begin
      heap_insert(lo_n == 0 || $signed(s) <= lo_heap[0], $signed(s));
      if (lo_n > hi_n + 1) begin
        heap_extract(1, m); heap_insert(0, m);
      end else if (hi_n > lo_n) begin
        heap_extract(0, m); heap_insert(1, m);
      end
    end
    r.median = lo_n > 0 ? lo_heap[0] : '0;
    return r;
  endfunction

  task automatic send_sample(input logic [VW-1:0] s, input logic rs);
    in_valid <= 1'b1; sample <= s; restart <= rs;
    do @(posedge clk); while (in_stall);
    medians_due.push_back(track_median(s, rs));
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // output checker
  always @(posedge clk) begin
    median_result_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (medians_due.size() == 0) report("output transaction with none expected");
      else begin
        e = medians_due.pop_front();
        if (median !== e.median)
          report($sformatf("median %0d, expected %0d", $signed(median), $signed(e.median)));
        if (dropped !== e.dropped)
          report($sformatf("dropped %0b, expected %0b", dropped, e.dropped));
      end
    end
  end

  // receiver stall pattern: stretches of free flow and stretches of heavy stalls
  always @(negedge clk) begin
    int phase;
    phase = int'((cycles / 300) % 3);
    if (phase == 0) out_stall <= 1'b0;
    else if (phase == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("running_median_two_heaps_top_test NOT OK");
      $finish;
    end
  end

  stim_row_t directed [] = '{
    '{16'h0005, 1'b0, 1'b1, 16'h0005, 1'b0},
    '{16'h7fff, 1'b0, 1'b1, 16'h0005, 1'b0},
    '{16'h8000, 1'b0, 1'b1, 16'h0005, 1'b0},
    '{16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'hffff, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h7fff, 1'b1, 1'b1, 16'h7fff, 1'b0},
    '{16'h7fff, 1'b0, 1'b1, 16'h7fff, 1'b0},
    '{16'h8000, 1'b1, 1'b1, 16'h8000, 1'b0},
    '{16'h8000, 1'b0, 1'b1, 16'h8000, 1'b0},
    '{16'h8000, 1'b0, 1'b1, 16'h8000, 1'b0},
    '{16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h5555, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'haaaa, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'hffff, 1'b1, 1'b1, 16'hffff, 1'b0}
  };

  initial begin
    logic [VW-1:0] v;
    int fill, span;
    errors = 0; cycles = 0; lo_n = 0; hi_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      if (directed[k].known)
        medians_due.push_back(median_result_t'{directed[k].median, directed[k].dropped});
      // keep predictor in step; known rows are checked against typed values
      if (directed[k].known) begin
        void'(track_median(directed[k].sample, directed[k].restart));
        in_valid <= 1'b1; sample <= directed[k].sample; restart <= directed[k].restart;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
      end else send_sample(directed[k].sample, directed[k].restart);
    end

    // fill to capacity and past it, then restart while full
    for (int k = 0; k < CAP + 3; k++) begin
      case ($urandom_range(0, 3))
        0: v = VW'($urandom);
        1: v = VW'($urandom_range(0, 40));
        2: v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: v = VW'(16'hfff0 + $urandom_range(0, 15));
      endcase
      send_sample(v, k == 0);
      if ((k % 64) == 0) idle_gap();
    end
    send_sample(VW'($urandom), 1'b1);

    // short random sequences with random restarts
    fill = 0;
    while (fill < 20) begin
      span = $urandom_range(1, 8);
      for (int k = 0; k < span; k++) begin
        case ($urandom_range(0, 3))
          0: v = VW'($urandom);
          1: v = VW'($urandom_range(0, 7));
          2: v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          default: v = VW'(16'hfff0 + $urandom_range(0, 15));
        endcase
        send_sample(v, k == 0 && $urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0) idle_gap();
      end
      fill += span;
    end
    in_valid <= 1'b0;

    while (medians_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("running_median_two_heaps_top_test OK");
    else $display("running_median_two_heaps_top_test NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
sv/rmh_pkg.sv
sv/rmh_ram.sv
sv/rmh_heap_engine.sv
sv/running_median_two_heaps_top.sv
tb/sv/running_median_two_heaps_top_test.sv
